[rtl/als_pkg.sv]
package als_pkg;

  // store geometry
  localparam int LED_COUNT = 64;
  localparam int ADDR_W    = $clog2(LED_COUNT);
  localparam int IDX_W     = 6;
  localparam int COLOR_W   = 24;
  localparam int BIT_W     = 5;

  // frame position: color bits plus up to 255 trailing zero slots
  localparam int POS_W     = $clog2(LED_COUNT * COLOR_W + 256);
  localparam int LEDPOS_W  = $clog2((LED_COUNT * COLOR_W + 256) / COLOR_W + 1);

  // register widths
  localparam int ACTIVE_W  = 7;
  localparam int DUTY_W    = 6;
  localparam int RSLOT_W   = 8;
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 8;
  localparam int ACT_W     = 3;

  localparam int LAST_MAX_I = (LED_COUNT - 1 < 63) ? LED_COUNT - 1 : 63;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(LAST_MAX_I);
  localparam logic [ACTIVE_W-1:0] USED_MAX = ACTIVE_W'(LED_COUNT);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(COLOR_W - 1);

  // actions
  localparam logic [ACT_W-1:0] ACT_WRITE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FILL  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_START = 3'd2;
  localparam logic [ACT_W-1:0] ACT_STOP  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_TICK  = 3'd4;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_ACTIVE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_DUTY1  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_DUTY0  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_RSLOTS = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming item
    logic fill_we;   // write one entry of a fill range
    logic fire;      // commit the item and load the result register
  } als_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_fill;        // incoming item is a fill
    logic in_fill_empty;  // incoming fill range holds no entry
    logic fill_last;      // current fill entry is the last one
    logic out_free;       // result register can take a new result
  } als_sts_t;

endpackage

[rtl/als_ram.sv]
module als_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/als_ctrl.sv]
module als_ctrl import als_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  als_sts_t sts,
  output als_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FILL = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  assign in_tready   = (state_r == ST_IDLE);
  assign accept      = in_tvalid && in_tready;
  assign cmd.capture = accept;
  assign cmd.fill_we = (state_r == ST_FILL);
  assign cmd.fire    = (state_r == ST_EMIT) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (sts.in_fill && !sts.in_fill_empty) ? ST_FILL : ST_EMIT;
        end
      end
      ST_FILL: begin
        if (sts.fill_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/als_dpath.sv]
module als_dpath import als_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  als_cmd_t            cmd,
  output als_sts_t            sts,
  input  logic [39:0]         in_tdata,
  input  logic [ACT_W-1:0]    in_tuser,
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tuser,
  output logic                out_tlast
);

  // incoming fields
  logic [IDX_W-1:0]   in_first, in_last, in_last_clamp;
  logic [COLOR_W-1:0] in_color;

  assign in_first      = in_tdata[5:0];
  assign in_last       = in_tdata[11:6];
  assign in_color      = {in_tdata[27:20], in_tdata[19:12], in_tdata[35:28]};
  assign in_last_clamp = (in_last > IDX_MAX) ? IDX_MAX : in_last;

  // configuration
  logic [ACTIVE_W-1:0] active_r;
  logic [DUTY_W-1:0]   duty1_r, duty0_r;
  logic [RSLOT_W-1:0]  rslots_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_W'(64);
      duty1_r  <= DUTY_W'(40);
      duty0_r  <= DUTY_W'(20);
      rslots_r <= RSLOT_W'(39);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ACTIVE: active_r <= cfg_wdata[ACTIVE_W-1:0];
        REG_DUTY1:  duty1_r  <= cfg_wdata[DUTY_W-1:0];
        REG_DUTY0:  duty0_r  <= cfg_wdata[DUTY_W-1:0];
        REG_RSLOTS: rslots_r <= cfg_wdata[RSLOT_W-1:0];
        default:    ;
      endcase
    end
  end

  // captured item
  logic [ACT_W-1:0]   act_r;
  logic [IDX_W-1:0]   first_r, last_r, fill_idx_r;
  logic [COLOR_W-1:0] color_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r   <= in_tuser;
      first_r <= in_first;
      last_r  <= in_last_clamp;
      color_r <= in_color;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fill_idx_r <= in_first;
    end else if (cmd.fill_we) begin
      fill_idx_r <= fill_idx_r + IDX_W'(1);
    end
  end

  // color store with per-entry valid bits
  logic               ram_we, write_ok;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [COLOR_W-1:0] ram_rdata;
  logic [LED_COUNT-1:0] vld_r;
  logic               rd_vld_r;

  logic [LEDPOS_W-1:0] led_r;
  logic [BIT_W-1:0]    bit_r;
  logic [POS_W-1:0]    pos_r;
  logic                running_r, sending_r;

  assign write_ok  = (32'(first_r) < 32'(LED_COUNT));
  assign ram_we    = cmd.fill_we || (cmd.fire && (act_r == ACT_WRITE) && write_ok);
  assign ram_waddr = cmd.fill_we ? ADDR_W'(fill_idx_r) : ADDR_W'(first_r);
  assign ram_raddr = led_r[ADDR_W-1:0];

  als_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (LED_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (color_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ram_we) begin
      vld_r[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r <= vld_r[ram_raddr];
  end

  // slot sequencing
  logic [ACTIVE_W-1:0] used;
  logic [POS_W-1:0]    bits;
  logic [POS_W:0]      len, pos_inc;
  logic                in_bits, frame_end, color_bit, tick_go;
  logic [COLOR_W-1:0]  rd_color;
  logic [DUTY_W-1:0]   duty;

  assign used      = (active_r > USED_MAX) ? USED_MAX : active_r;
  assign bits      = POS_W'(used) * POS_W'(COLOR_W);
  assign len       = {1'b0, bits} + (POS_W+1)'(rslots_r);
  assign pos_inc   = {1'b0, pos_r} + (POS_W+1)'(1);
  assign in_bits   = (pos_r < bits);
  assign frame_end = (pos_inc >= len);
  assign rd_color  = rd_vld_r ? ram_rdata : '0;
  assign color_bit = rd_color[BIT_LAST - bit_r];
  assign duty      = in_bits ? (color_bit ? duty1_r : duty0_r) : '0;
  assign tick_go   = cmd.fire && (act_r == ACT_TICK) && sending_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      led_r     <= '0;
      bit_r     <= '0;
      running_r <= 1'b0;
      sending_r <= 1'b0;
    end else if (cmd.fire) begin
      case (act_r)
        ACT_START: begin
          running_r <= 1'b1;
          sending_r <= 1'b1;
          pos_r     <= '0;
          led_r     <= '0;
          bit_r     <= '0;
        end
        ACT_STOP: begin
          running_r <= 1'b0;
        end
        ACT_TICK: begin
          if (sending_r) begin
            if (frame_end) begin
              pos_r     <= '0;
              led_r     <= '0;
              bit_r     <= '0;
              sending_r <= running_r;
            end else begin
              pos_r <= pos_inc[POS_W-1:0];
              if (bit_r == BIT_LAST) begin
                bit_r <= '0;
                led_r <= led_r + LEDPOS_W'(1);
              end else begin
                bit_r <= bit_r + BIT_W'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  logic             out_valid_r;
  logic [DUTY_W-1:0] out_duty_r;
  logic             out_act_r, out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      out_duty_r <= tick_go ? duty : '0;
      out_act_r  <= tick_go;
      out_end_r  <= tick_go && frame_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_duty_r};
  assign out_tuser  = out_act_r;
  assign out_tlast  = out_end_r;

  assign sts.in_fill       = (in_tuser == ACT_FILL);
  assign sts.in_fill_empty = (in_first > in_last_clamp);
  assign sts.fill_last     = (fill_idx_r == last_r);
  assign sts.out_free      = !out_valid_r || out_tready;

  // checks
  logic [POS_W:0] pos_calc;
  assign pos_calc = (POS_W+1)'(led_r) * (POS_W+1)'(COLOR_W) + (POS_W+1)'(bit_r);

  a_pos_split: assert property (@(posedge clk) disable iff (!rst_n)
    pos_calc == {1'b0, pos_r})
    else $error("slot position out of step with led and bit counters");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= BIT_LAST)
    else $error("bit counter past last color bit");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    tick_go && frame_end |=> pos_r == '0)
    else $error("position did not wrap at frame end");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.fire))
    else $error("result appeared without a commit");

endmodule

[rtl/addressable_led_serializer_core.sv]
// Addressable LED serializer. Holds 64 colors (green:red:blue) and turns them,
// one transfer per bit period tick, into PWM compare values: each active LED's
// 24 color bits go out MSB first as duty_one or duty_zero, then reset_slots
// zero-duty slots close the frame, and frames repeat until a stop lets the
// current one finish. Colors are read from the store when their bit goes out.
// Every input transfer gives exactly one result transfer. Write, start, stop,
// tick and unknown actions are captured at the input transfer and committed
// into the result register once it is free; a fill first walks its range
// through the single store write port, one entry per cycle, ahead of the
// commit. A new input is taken once the previous item has committed, while
// its result may still sit in the output register. The store needs no
// clearing pass after reset: per-entry valid bits make unwritten entries read
// as zero. Configuration must be written by the user through
// cfg_we/cfg_addr/cfg_wdata while idle; the block does not enforce it.
// Index 0 active_leds, 1 duty_one, 2 duty_zero, 3 reset_slots.
module addressable_led_serializer_core import als_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  // led_index[5:0], last_index[11:6], red[19:12], green[27:20], blue[35:28]
  input  logic [39:0]       in_tdata,
  // action[2:0]
  input  logic [ACT_W-1:0]  in_tuser,
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  // duty[5:0]
  output logic [7:0]        out_tdata,
  // slot_active
  output logic              out_tuser,
  // frame_end
  output logic              out_tlast,
  // configuration write port
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  als_cmd_t cmd;
  als_sts_t sts;

  // sequencer: accept, walk fill ranges, commit
  als_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // color store, frame counters, registers and result register
  als_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
